@@ rtl/xoroshiro_random_generator_top_assert.svh @@
// Assertion macros for the generator top level.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef XOROSHIRO_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define XOROSHIRO_RANDOM_GENERATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define XRG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define XRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/xrg_pkg.sv @@
package xrg_pkg;

  // Splitmix64 constants.
  localparam logic [63:0] GOLDEN_STEP  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] GOLDEN_TWICE = {GOLDEN_STEP[62:0], 1'b0};
  localparam logic [63:0] MIX_MUL_ONE  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_TWO  = 64'h94d049bb133111eb;

  // Splitmix64 shift amounts.
  localparam int unsigned MIX_SHIFT_PRE = 30;
  localparam int unsigned MIX_SHIFT_MID = 27;
  localparam int unsigned MIX_SHIFT_END = 31;

  // Xoroshiro128+ rotate and shift amounts.
  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned ROT_B   = 37;

  // Fraction output drops the low bits of a 64-bit draw.
  localparam int unsigned FRAC_SHIFT = 12;

  // Generator words after reset: splitmix64 of zero and of the golden constant.
  localparam logic [63:0] WORD_A_RESET = 64'he220a8397b1dcdaf;
  localparam logic [63:0] WORD_B_RESET = 64'h6e789e6aa1b965f4;

  // Division runs one quotient bit per step.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_SEED     = 3'd0,
    OP_DRAW64   = 3'd1,
    OP_DRAW32   = 3'd2,
    OP_RANGED   = 3'd3,
    OP_BOOL     = 3'd4,
    OP_FRACTION = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PRE,
    CMD_MUL0,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_WIDE,
    CMD_NARROW,
    CMD_DIV_STEP,
    CMD_RANGE,
    CMD_ZERO
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_WIDE,
    ST_NARROW,
    ST_DIV,
    ST_RANGE,
    ST_ZERO,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    cmd_e cmd;
    op_e  op;
    logic word;      // 0: generator word a, 1: generator word b
    logic pass;      // 0: first splitmix multiply, 1: second
    logic out_load;  // copy the finished result into the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic spare_rdy;
    logic span_zero;
    logic div_last;
  } sts_t;

endpackage

@@ rtl/xrg_req_if.sv @@
interface xrg_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] seed_value;
  logic [31:0] range_lower;
  logic [31:0] range_upper;

  modport source (
    output valid, operation, seed_value, range_lower, range_upper,
    input  ready
  );

  modport sink (
    input  valid, operation, seed_value, range_lower, range_upper,
    output ready
  );
endinterface

@@ rtl/xrg_rsp_if.sv @@
interface xrg_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (
    output valid, value,
    input  ready
  );

  modport sink (
    input  valid, value,
    output ready
  );
endinterface

@@ rtl/xrg_ctrl.sv @@
module xrg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      in_op_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  xrg_pkg::sts_t   sts_i,
  output xrg_pkg::ctl_t   ctl_o
);

  xrg_pkg::state_e state_q, state_d;
  xrg_pkg::op_e    op_q, op_d;
  logic            word_q, word_d;
  logic            pass_q, pass_d;
  logic            ovalid_q, ovalid_d;
  logic            out_load;

  // The output register can take a new result when empty or being drained.
  assign out_load = (state_q == xrg_pkg::ST_OUT) && (!ovalid_q || out_ready_i);

  // Next state and sequencing registers.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    word_d   = word_q;
    pass_d   = pass_q;
    ovalid_d = out_load | (ovalid_q & ~out_ready_i);
    case (state_q)
      xrg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = xrg_pkg::op_e'(in_op_i);
          word_d = 1'b0;
          pass_d = 1'b0;
          case (in_op_i)
            xrg_pkg::OP_SEED:     state_d = xrg_pkg::ST_PRE;
            xrg_pkg::OP_DRAW64,
            xrg_pkg::OP_BOOL,
            xrg_pkg::OP_FRACTION: state_d = xrg_pkg::ST_WIDE;
            xrg_pkg::OP_DRAW32,
            xrg_pkg::OP_RANGED:   state_d = xrg_pkg::ST_NARROW;
            default:              state_d = xrg_pkg::ST_ZERO;
          endcase
        end
      end
      xrg_pkg::ST_PRE:  state_d = xrg_pkg::ST_MUL0;
      xrg_pkg::ST_MUL0: state_d = xrg_pkg::ST_MUL1;
      xrg_pkg::ST_MUL1: state_d = xrg_pkg::ST_MUL2;
      xrg_pkg::ST_MUL2: state_d = xrg_pkg::ST_MUL3;
      xrg_pkg::ST_MUL3: begin
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = xrg_pkg::ST_MUL0;
        end else if (!word_q) begin
          word_d  = 1'b1;
          pass_d  = 1'b0;
          state_d = xrg_pkg::ST_PRE;
        end else begin
          state_d = xrg_pkg::ST_ZERO;
        end
      end
      xrg_pkg::ST_WIDE: state_d = xrg_pkg::ST_OUT;
      xrg_pkg::ST_NARROW: begin
        if (op_q != xrg_pkg::OP_RANGED) begin
          state_d = xrg_pkg::ST_OUT;
        end else if (sts_i.span_zero) begin
          state_d = xrg_pkg::ST_RANGE;
        end else begin
          state_d = xrg_pkg::ST_DIV;
        end
      end
      xrg_pkg::ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = xrg_pkg::ST_RANGE;
        end
      end
      xrg_pkg::ST_RANGE: state_d = xrg_pkg::ST_OUT;
      xrg_pkg::ST_ZERO:  state_d = xrg_pkg::ST_OUT;
      xrg_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = xrg_pkg::ST_IDLE;
        end
      end
      default: state_d = xrg_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands for the current state.
  always_comb begin
    ctl_o          = '0;
    ctl_o.op       = op_q;
    ctl_o.word     = word_q;
    ctl_o.pass     = pass_q;
    ctl_o.out_load = out_load;
    in_ready_o     = 1'b0;
    case (state_q)
      xrg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.cmd  = in_valid_i ? xrg_pkg::CMD_LOAD : xrg_pkg::CMD_NONE;
      end
      xrg_pkg::ST_PRE:    ctl_o.cmd = xrg_pkg::CMD_PRE;
      xrg_pkg::ST_MUL0:   ctl_o.cmd = xrg_pkg::CMD_MUL0;
      xrg_pkg::ST_MUL1:   ctl_o.cmd = xrg_pkg::CMD_MUL1;
      xrg_pkg::ST_MUL2:   ctl_o.cmd = xrg_pkg::CMD_MUL2;
      xrg_pkg::ST_MUL3:   ctl_o.cmd = xrg_pkg::CMD_MUL3;
      xrg_pkg::ST_WIDE:   ctl_o.cmd = xrg_pkg::CMD_WIDE;
      xrg_pkg::ST_NARROW: ctl_o.cmd = xrg_pkg::CMD_NARROW;
      xrg_pkg::ST_DIV:    ctl_o.cmd = xrg_pkg::CMD_DIV_STEP;
      xrg_pkg::ST_RANGE:  ctl_o.cmd = xrg_pkg::CMD_RANGE;
      xrg_pkg::ST_ZERO:   ctl_o.cmd = xrg_pkg::CMD_ZERO;
      default:            ctl_o.cmd = xrg_pkg::CMD_NONE;
    endcase
  end

  assign out_valid_o = ovalid_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= xrg_pkg::ST_IDLE;
      op_q     <= xrg_pkg::OP_SEED;
      word_q   <= 1'b0;
      pass_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      word_q   <= word_d;
      pass_q   <= pass_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

@@ rtl/xrg_datapath.sv @@
module xrg_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xrg_pkg::ctl_t   ctl_i,
  input  logic [63:0]     seed_value_i,
  input  logic [31:0]     range_lower_i,
  input  logic [31:0]     range_upper_i,
  output xrg_pkg::sts_t   sts_o,
  output logic [63:0]     value_o
);

  // Generator state.
  logic [63:0] wa_q, wb_q;
  logic [31:0] spare_q;
  logic        spare_rdy_q;

  // Captured item fields.
  logic [63:0] seed_q;
  logic [31:0] lo_q;
  logic [31:0] span_q;

  // Splitmix multiply sequencing.
  logic [63:0] z_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;

  // Restoring division.
  logic [31:0]                   dvd_q;
  logic [31:0]                   rem_q;
  logic [xrg_pkg::DIV_CNT_W-1:0] cnt_q;

  // Result and output registers.
  logic [63:0] res_q;
  logic [63:0] out_q;

  logic [63:0] sum;
  logic [63:0] mixed;
  logic [63:0] wa_step;
  logic [63:0] wb_step;
  logic [63:0] mix_in;
  logic [63:0] mix_k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mul_sum;
  logic [63:0] mix_done;
  logic [31:0] narrow_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_nx;
  logic [31:0] range_v;
  logic [63:0] wide_res;

  // One xoroshiro128+ step.
  assign sum     = wa_q + wb_q;
  assign mixed   = wa_q ^ wb_q;
  assign wa_step = ((wa_q << xrg_pkg::ROT_A) | (wa_q >> (64 - xrg_pkg::ROT_A)))
                   ^ mixed ^ (mixed << xrg_pkg::SHIFT_B);
  assign wb_step = (mixed << xrg_pkg::ROT_B) | (mixed >> (64 - xrg_pkg::ROT_B));

  // Splitmix input for word a or word b, and the multiplier constant of this pass.
  assign mix_in = seed_q + (ctl_i.word ? xrg_pkg::GOLDEN_TWICE : xrg_pkg::GOLDEN_STEP);
  assign mix_k  = ctl_i.pass ? xrg_pkg::MIX_MUL_TWO : xrg_pkg::MIX_MUL_ONE;

  // Low 64 bits of z * k from three 32x32 partial products.
  always_comb begin
    case (ctl_i.cmd)
      xrg_pkg::CMD_MUL1: begin
        mul_a = z_q[63:32];
        mul_b = mix_k[31:0];
      end
      xrg_pkg::CMD_MUL2: begin
        mul_a = z_q[31:0];
        mul_b = mix_k[63:32];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mix_k[31:0];
      end
    endcase
  end

  assign mul_p    = {32'b0, mul_a} * {32'b0, mul_b};
  assign mul_sum  = acc_q + {prod_q[31:0], 32'b0};
  assign mix_done = mul_sum ^ (mul_sum >> xrg_pkg::MIX_SHIFT_END);

  // 32-bit draw: the stored lower half first, otherwise the upper half of a new draw.
  assign narrow_r = spare_rdy_q ? spare_q : sum[63:32];

  // One restoring division step.
  assign rem_sh = {rem_q, dvd_q[31]};
  assign rem_nx = (rem_sh >= {1'b0, span_q}) ? (rem_sh - {1'b0, span_q}) : rem_sh;

  // A zero span passes the draw through unchanged.
  assign range_v = (span_q == 32'd0) ? dvd_q : rem_q;

  // Result of a wide draw, by operation.
  always_comb begin
    case (ctl_i.op)
      xrg_pkg::OP_BOOL:     wide_res = {63'b0, sum[63]};
      xrg_pkg::OP_FRACTION: wide_res = sum >> xrg_pkg::FRAC_SHIFT;
      default:              wide_res = sum;
    endcase
  end

  // Generator state and the division counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q        <= xrg_pkg::WORD_A_RESET;
      wb_q        <= xrg_pkg::WORD_B_RESET;
      spare_q     <= 32'd0;
      spare_rdy_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      case (ctl_i.cmd)
        xrg_pkg::CMD_MUL3: begin
          if (ctl_i.pass) begin
            if (ctl_i.word) begin
              wb_q        <= mix_done;
              spare_rdy_q <= 1'b0;
            end else begin
              wa_q <= mix_done;
            end
          end
        end
        xrg_pkg::CMD_WIDE: begin
          wa_q <= wa_step;
          wb_q <= wb_step;
        end
        xrg_pkg::CMD_NARROW: begin
          cnt_q <= '0;
          if (spare_rdy_q) begin
            spare_rdy_q <= 1'b0;
          end else begin
            wa_q        <= wa_step;
            wb_q        <= wb_step;
            spare_q     <= sum[31:0];
            spare_rdy_q <= 1'b1;
          end
        end
        xrg_pkg::CMD_DIV_STEP: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Working registers for the current item.
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      xrg_pkg::CMD_LOAD: begin
        seed_q <= seed_value_i;
        lo_q   <= range_lower_i;
        span_q <= range_upper_i - range_lower_i + 32'd1;
      end
      xrg_pkg::CMD_PRE: z_q <= mix_in ^ (mix_in >> xrg_pkg::MIX_SHIFT_PRE);
      xrg_pkg::CMD_MUL0: prod_q <= mul_p;
      xrg_pkg::CMD_MUL1: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      xrg_pkg::CMD_MUL2: begin
        acc_q  <= mul_sum;
        prod_q <= mul_p;
      end
      xrg_pkg::CMD_MUL3: begin
        if (!ctl_i.pass) begin
          z_q <= mul_sum ^ (mul_sum >> xrg_pkg::MIX_SHIFT_MID);
        end
      end
      xrg_pkg::CMD_WIDE: res_q <= wide_res;
      xrg_pkg::CMD_NARROW: begin
        res_q <= {32'b0, narrow_r};
        dvd_q <= narrow_r;
        rem_q <= 32'd0;
      end
      xrg_pkg::CMD_DIV_STEP: begin
        rem_q <= rem_nx[31:0];
        dvd_q <= {dvd_q[30:0], 1'b0};
      end
      xrg_pkg::CMD_RANGE: res_q <= {32'b0, range_v + lo_q};
      xrg_pkg::CMD_ZERO:  res_q <= 64'd0;
      default: ;
    endcase
    if (ctl_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.spare_rdy = spare_rdy_q;
  assign sts_o.span_zero = (span_q == 32'd0);
  assign sts_o.div_last  = (cnt_q == xrg_pkg::DIV_CNT_W'(xrg_pkg::DIV_STEPS - 1));
  assign value_o         = out_q;

endmodule

@@ rtl/xoroshiro_random_generator_top.sv @@
// Channel   Dir   Beat contents
// req_i     in    operation, seed_value, range_lower, range_upper
// rsp_o     out   value
//
// One item is in work at a time; the block takes a new item once the previous
// result has been moved into the output register, which may still be waiting.
// A ranged draw divides at one quotient bit per cycle unless its span is zero,
// and a seed runs two splitmix64 passes on one shared 32x32 multiplier.
// Reset is asynchronous, active low, and loads the state of a seed of zero.
// A stalled output beat holds; the next item can already be taken.
`include "xoroshiro_random_generator_top_assert.svh"

module xoroshiro_random_generator_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  xrg_req_if.sink         req_i,
  xrg_rsp_if.source       rsp_o
);

  xrg_pkg::ctl_t ctl;
  xrg_pkg::sts_t sts;
  logic          spare_cmd;
  logic          div_end;

  // Sequencer for the item in work.
  xrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Generator state, splitmix multiplier, divider and result registers.
  xrg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .seed_value_i  (req_i.seed_value),
    .range_lower_i (req_i.range_lower),
    .range_upper_i (req_i.range_upper),
    .sts_o         (sts),
    .value_o       (rsp_o.value)
  );

  // Commands that may clear the spare flag, and the last division step.
  assign spare_cmd = (ctl.cmd == xrg_pkg::CMD_NARROW) || (ctl.cmd == xrg_pkg::CMD_MUL3);
  assign div_end   = (ctl.cmd == xrg_pkg::CMD_DIV_STEP) && sts.div_last;

  // Only one item is in work at a time.
  `XRG_ASSERT_NEXT(a_one_item, req_i.valid && req_i.ready, !req_i.ready, "accepted while busy")

  // The spare half is consumed only by a narrow draw or cleared by a seed.
  `XRG_ASSERT_SAME(a_spare_clear, $fell(sts.spare_rdy), $past(spare_cmd), "spare half dropped")

  // The last division step is followed by the range result.
  `XRG_ASSERT_NEXT(a_div_end, div_end, ctl.cmd == xrg_pkg::CMD_RANGE, "division did not finish")

  // Loading the output register always presents a beat.
  `XRG_ASSERT_NEXT(a_out_valid, ctl.out_load, rsp_o.valid, "loaded result not presented")

endmodule
